[design/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants of the connection slot table
// Command and status codes, field widths of the request and result ports,
// and the controller's sequencer states.
// ----------------------------------------------------------------------------
package csl_pkg;

	localparam int HANDLE_FIELD_W = 16;
	localparam int STATUS_FIELD_W = 3;
	localparam int SLOT_FIELD_W   = 6;
	localparam int COUNT_FIELD_W  = 7;

	typedef enum logic {
		CMD_ADD    = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_FIELD_W-1:0] {
		ST_ADDED     = 3'd0,
		ST_PRESENT   = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_RESP
	} seq_state_t;

endpackage

[design/connection_slot_table_unit.sv]
// ----------------------------------------------------------------------------
// connection_slot_table_unit: connection handle slot table
// Adds and removes connection handles in a table of SLOTS entries with
// first-free allocation behind a high-water mark; every answer carries
// the number of occupied slots.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   request  | req_valid / req_stall  | cmd, handle
//   response | rsp_valid / rsp_stall  | status, slot, live_count
//
// One request is in work at a time. With H slots ever used (the
// high-water mark), a request reads H memory entries one per cycle, a
// rate set by the single memory read port, and the next request is
// taken in the cycle after the response leaves. A hit ends the scan
// early. No clearing pass follows reset: entries at or above the
// high-water mark are never read. req_stall stays high while a request
// is in work or its response is stalled.
// ----------------------------------------------------------------------------
module connection_slot_table_unit #(
	parameter int SLOTS = 64,
	parameter int HANDLE_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      req_valid,
	output logic                                      req_stall,
	input  logic                                      cmd,
	input  logic [csl_pkg::HANDLE_FIELD_W-1:0]        handle,
	output logic                                      rsp_valid,
	input  logic                                      rsp_stall,
	output logic [csl_pkg::STATUS_FIELD_W-1:0]        status,
	output logic [csl_pkg::SLOT_FIELD_W-1:0]          slot,
	output logic [csl_pkg::COUNT_FIELD_W-1:0]         live_count
);

	import csl_pkg::*;

	// Handle bits above the field width never reach the block.
	localparam int KEY_W = (HANDLE_BITS < HANDLE_FIELD_W) ? HANDLE_BITS : HANDLE_FIELD_W;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int MW = KEY_W + 1;

	status_t           ctl_status;
	logic [IDX_W-1:0]  ctl_slot;
	logic [CNT_W-1:0]  ctl_count;
	logic              wr_en, rd_en;
	logic [IDX_W-1:0]  wr_addr, rd_addr;
	logic [MW-1:0]     wr_data, rd_data;

	csl_ctrl #(
		.SLOTS (SLOTS),
		.KEY_W (KEY_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.cmd         (cmd_t'(cmd)),
		.key         (handle[KEY_W-1:0]),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (ctl_status),
		.slot        (ctl_slot),
		.live_count  (ctl_count),
		.mem_wr_en   (wr_en),
		.mem_wr_addr (wr_addr),
		.mem_wr_data (wr_data),
		.mem_rd_en   (rd_en),
		.mem_rd_addr (rd_addr),
		.mem_rd_data (rd_data)
	);

	csl_mem #(
		.DEPTH (SLOTS),
		.WIDTH (MW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign status = ctl_status;
	assign slot = SLOT_FIELD_W'(ctl_slot);
	assign live_count = COUNT_FIELD_W'(ctl_count);

endmodule

[design/csl_mem.sv]
// ----------------------------------------------------------------------------
// csl_mem: slot entry memory
// Simple dual-port synchronous RAM, one write and one registered read per
// cycle. Each word holds a busy bit above the stored handle.
// ----------------------------------------------------------------------------
module csl_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 17,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/csl_ctrl.sv]
// ----------------------------------------------------------------------------
// csl_ctrl: scan sequencer of the connection slot table
// Reads the used part of the slot memory one entry a cycle, looks for the
// handle and the lowest free slot, then writes back any change and holds the result.
// ----------------------------------------------------------------------------
module csl_ctrl #(
	parameter int SLOTS = 64,
	parameter int KEY_W = 16,
	localparam int IDX_W = $clog2(SLOTS),
	localparam int CNT_W = $clog2(SLOTS + 1),
	localparam int MW = KEY_W + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  csl_pkg::cmd_t       cmd,
	input  logic [KEY_W-1:0]    key,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output csl_pkg::status_t    status,
	output logic [IDX_W-1:0]    slot,
	output logic [CNT_W-1:0]    live_count,
	output logic                mem_wr_en,
	output logic [IDX_W-1:0]    mem_wr_addr,
	output logic [MW-1:0]       mem_wr_data,
	output logic                mem_rd_en,
	output logic [IDX_W-1:0]    mem_rd_addr,
	input  logic [MW-1:0]       mem_rd_data
);

	import csl_pkg::*;

	seq_state_t        state_q, state_d;
	cmd_t              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  hw_q, hw_d;
	logic [CNT_W-1:0]  occ_q, occ_d;
	logic [CNT_W-1:0]  addr_q;
	logic              rd_v_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              have_free_q;
	logic [IDX_W-1:0]  free_idx_q;
	status_t           status_q, res_status;
	logic [IDX_W-1:0]  slot_q, res_slot;
	logic [CNT_W-1:0]  count_q;
	logic              accept, rd_en, hit, hole, drained, finish;

	assign accept = req_valid && (state_q == SEQ_IDLE);
	assign rd_en = (state_q == SEQ_SCAN) && (addr_q < hw_q);
	assign hit = (state_q == SEQ_SCAN) && rd_v_s1 && mem_rd_data[KEY_W]
		&& (mem_rd_data[KEY_W-1:0] == key_q);
	assign hole = (state_q == SEQ_SCAN) && rd_v_s1 && !mem_rd_data[KEY_W];
	// The scan is over once no read is issued and none is still in flight.
	assign drained = (state_q == SEQ_SCAN) && !rd_en && !rd_v_s1;

	assign mem_rd_en = rd_en;
	assign mem_rd_addr = addr_q[IDX_W-1:0];

	// Outcome of the scan and the write-back that goes with it.
	always_comb begin
		finish = 1'b0;
		mem_wr_en = 1'b0;
		mem_wr_addr = rd_idx_s1;
		mem_wr_data = {1'b0, key_q};
		res_status = ST_NOT_FOUND;
		res_slot = '0;
		occ_d = occ_q;
		hw_d = hw_q;
		priority if (hit) begin
			finish = 1'b1;
			res_slot = rd_idx_s1;
			if (cmd_q == CMD_ADD) begin
				res_status = ST_PRESENT;
			end else begin
				res_status = ST_REMOVED;
				mem_wr_en = 1'b1;
				occ_d = occ_q - CNT_W'(1);
			end
		end else if (drained) begin
			finish = 1'b1;
			if (cmd_q == CMD_REMOVE) begin
				res_status = ST_NOT_FOUND;
			end else if (have_free_q) begin
				res_status = ST_ADDED;
				res_slot = free_idx_q;
				mem_wr_en = 1'b1;
				mem_wr_addr = free_idx_q;
				mem_wr_data = {1'b1, key_q};
				occ_d = occ_q + CNT_W'(1);
			end else if (hw_q == CNT_W'(SLOTS)) begin
				res_status = ST_FULL;
			end else begin
				res_status = ST_ADDED;
				res_slot = hw_q[IDX_W-1:0];
				mem_wr_en = 1'b1;
				mem_wr_addr = hw_q[IDX_W-1:0];
				mem_wr_data = {1'b1, key_q};
				occ_d = occ_q + CNT_W'(1);
				hw_d = hw_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: if (req_valid) state_d = SEQ_SCAN;
			SEQ_SCAN: if (finish) state_d = SEQ_RESP;
			SEQ_RESP: if (!rsp_stall) state_d = SEQ_IDLE;
			default:  state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != SEQ_IDLE);
		rsp_valid = (state_q == SEQ_RESP);
		status = status_q;
		slot = slot_q;
		live_count = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			rd_v_s1 <= 1'b0;
			hw_q <= '0;
			occ_q <= '0;
			have_free_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			if (accept) begin
				have_free_q <= 1'b0;
			end else if (hole && !have_free_q) begin
				have_free_q <= 1'b1;
			end
			if (finish) begin
				hw_q <= hw_d;
				occ_q <= occ_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			key_q <= key;
			addr_q <= '0;
		end else if (rd_en) begin
			addr_q <= addr_q + CNT_W'(1);
		end
		rd_idx_s1 <= addr_q[IDX_W-1:0];
		if (hole && !have_free_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (finish) begin
			status_q <= res_status;
			slot_q <= res_slot;
			count_q <= occ_d;
		end
	end

endmodule

[design/csl_checker.sv]
// ----------------------------------------------------------------------------
// csl_checker: port-level checks of the connection slot table
// Watches the request and response channels of the top level and is bound
// to it below.
// ----------------------------------------------------------------------------
module csl_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 req_valid,
	input logic                                 req_stall,
	input logic                                 rsp_valid,
	input logic                                 rsp_stall,
	input logic [csl_pkg::STATUS_FIELD_W-1:0]   status,
	input logic [csl_pkg::SLOT_FIELD_W-1:0]     slot,
	input logic [csl_pkg::COUNT_FIELD_W-1:0]    live_count
);

	import csl_pkg::*;

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot)
			&& $stable(live_count))
		else $error("stalled response changed");

	// After a request transaction the block takes no other until it answers.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in work");

	// A response is never shown while the request side is open.
	a_rsp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("response valid while requests are taken");

	// Refusals and misses report slot zero.
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_NOT_FOUND || status == ST_FULL) |-> slot == '0)
		else $error("nonzero slot on a miss");

	// An added or present handle means at least one slot is occupied.
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_ADDED || status == ST_PRESENT) |-> live_count != '0)
		else $error("live count zero with a handle in the table");

endmodule

bind connection_slot_table_unit csl_checker u_csl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req_valid),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.status     (status),
	.slot       (slot),
	.live_count (live_count)
);

[bench/tb_connection_slot_table_unit.sv]
// ----------------------------------------------------------------------------
// tb_connection_slot_table_unit: testbench of the connection slot table
// Drives add and remove requests through the request channel and checks
// every response against a behavioral copy of the slot table: first a short
// table of directed requests, then phases of random traffic that fill the
// table, churn it at full occupancy, drain it and reuse freed slots.
// ----------------------------------------------------------------------------
module tb_connection_slot_table_unit;
	import csl_pkg::*;

	localparam int TBL_SLOTS   = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 300;
	localparam int IDLE_PCT    = 17;
	localparam logic [HANDLE_FIELD_W-1:0] ANY_HANDLE = '1;

	typedef struct packed {
		status_t                    status;
		logic [SLOT_FIELD_W-1:0]    slot;
		logic [COUNT_FIELD_W-1:0]   count;
	} slot_answer_t;

	typedef struct packed {
		cmd_t                       op;
		logic [HANDLE_FIELD_W-1:0]  hdl;
		bit                         typed;
		slot_answer_t               want;
	} intro_row_t;

	localparam slot_answer_t UNTYPED = '{ST_ADDED, 6'd0, 7'd0};

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        req_valid = 1'b0;
	logic                        req_stall;
	cmd_t                        cmd = CMD_ADD;
	logic [HANDLE_FIELD_W-1:0]   handle = '0;
	logic                        rsp_valid;
	logic                        rsp_stall = 1'b0;
	logic [STATUS_FIELD_W-1:0]   status;
	logic [SLOT_FIELD_W-1:0]     slot;
	logic [COUNT_FIELD_W-1:0]    live_count;

	// Behavioral copy of the table.
	logic [HANDLE_FIELD_W-1:0]   m_handle [TBL_SLOTS];
	bit                          m_busy [TBL_SLOTS];
	int                          m_mark = 0;
	int                          m_live = 0;

	slot_answer_t                answer_q [$];
	intro_row_t                  intro_rows [0:23];
	bit                          typed_now = 1'b0;
	slot_answer_t                typed_want = UNTYPED;
	bit                          idle_on = 1'b1;
	bit                          hold_req = 1'b0;
	int                          hold_left = 0;
	int                          mismatch_cnt = 0;
	int                          cycle_cnt = 0;

	connection_slot_table_unit #(
		.SLOTS(TBL_SLOTS),
		.HANDLE_BITS(HANDLE_FIELD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.handle(handle),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.slot(slot),
		.live_count(live_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Applies one request to the table copy and returns the answer it earns.
	task automatic apply_slot_request(input cmd_t op, input logic [HANDLE_FIELD_W-1:0] h,
			output slot_answer_t ans);
		bit hit;
		bit have_free;
		int free_at;
		hit = 1'b0;
		have_free = 1'b0;
		free_at = 0;
		ans = UNTYPED;
		for (int i = 0; i < m_mark; i++) begin
			if (m_busy[i] && m_handle[i] == h) begin
				hit = 1'b1;
				ans.slot = i[SLOT_FIELD_W-1:0];
				break;
			end
			if (!m_busy[i] && !have_free) begin
				have_free = 1'b1;
				free_at = i;
			end
		end
		if (op == CMD_ADD) begin
			if (hit) begin
				ans.status = ST_PRESENT;
			end else if (!have_free && m_mark >= TBL_SLOTS) begin
				ans.status = ST_FULL;
			end else begin
				// The lowest free slot below the mark wins over appending.
				if (!have_free) begin
					free_at = m_mark;
					m_mark++;
				end
				m_handle[free_at] = h;
				m_busy[free_at] = 1'b1;
				m_live++;
				ans.status = ST_ADDED;
				ans.slot = free_at[SLOT_FIELD_W-1:0];
			end
		end else if (hit) begin
			m_busy[ans.slot] = 1'b0;
			m_live--;
			ans.status = ST_REMOVED;
		end else begin
			ans.status = ST_NOT_FOUND;
		end
		ans.count = m_live[COUNT_FIELD_W-1:0];
	endtask

	// Predicts at each accepted request, then checks each accepted response.
	always @(posedge clk) begin
		slot_answer_t exp_ans;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				apply_slot_request(cmd, handle, exp_ans);
				if (typed_now)
					exp_ans = typed_want;
				answer_q.push_back(exp_ans);
			end
			if (rsp_valid && !rsp_stall) begin
				if (answer_q.size() == 0) begin
					$display("%0t: response with none expected: status %0d slot %0d count %0d",
						$time, status, slot, live_count);
					mismatch_cnt++;
				end else begin
					exp_ans = answer_q.pop_front();
					if (status !== exp_ans.status) begin
						$display("%0t: status expected %0d, actual %0d",
							$time, exp_ans.status, status);
						mismatch_cnt++;
					end
					if (slot !== exp_ans.slot) begin
						$display("%0t: slot expected %0d, actual %0d",
							$time, exp_ans.slot, slot);
						mismatch_cnt++;
					end
					if (live_count !== exp_ans.count) begin
						$display("%0t: live_count expected %0d, actual %0d",
							$time, exp_ans.count, live_count);
						mismatch_cnt++;
					end
				end
			end
		end
	end

	// Response side: random stalls, or a long hold-off when asked for one.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else begin
			rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Returns at the falling edge where the next transaction may be offered.
	task automatic next_turn();
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(99) < IDLE_PCT)
			gap = $urandom_range(4, 1);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
	endtask

	task automatic offer(input cmd_t op, input logic [HANDLE_FIELD_W-1:0] h,
			input bit typed, input slot_answer_t want);
		req_valid <= 1'b1;
		cmd <= op;
		handle <= h;
		typed_now = typed;
		typed_want = want;
		forever begin
			@(posedge clk);
			if (!req_stall)
				break;
		end
	endtask

	task automatic wait_all_answered();
		@(negedge clk);
		req_valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int n, input int add_pct, input int live_pct,
			input logic [HANDLE_FIELD_W-1:0] pool, input int hold_at);
		cmd_t op;
		logic [HANDLE_FIELD_W-1:0] h;
		int idx;
		for (int k = 0; k < n; k++) begin
			next_turn();
			op = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_REMOVE;
			if (m_live > 0 && $urandom_range(99) < live_pct) begin
				// Reuse a handle that is in the table right now.
				do
					idx = $urandom_range(m_mark - 1);
				while (!m_busy[idx]);
				h = m_handle[idx];
			end else begin
				h = $urandom_range(pool);
			end
			offer(op, h, 1'b0, UNTYPED);
			if (k == hold_at)
				hold_req = 1'b1;
		end
	endtask

	initial begin
		intro_rows = '{
			'{CMD_REMOVE, 16'h0000, 1'b1, '{ST_NOT_FOUND, 6'd0, 7'd0}},
			'{CMD_ADD,    16'h0000, 1'b1, '{ST_ADDED,     6'd0, 7'd1}},
			'{CMD_ADD,    16'h0000, 1'b1, '{ST_PRESENT,   6'd0, 7'd1}},
			'{CMD_ADD,    16'hFFFF, 1'b1, '{ST_ADDED,     6'd1, 7'd2}},
			'{CMD_ADD,    16'hFFFF, 1'b0, UNTYPED},
			'{CMD_ADD,    16'h8000, 1'b0, UNTYPED},
			'{CMD_ADD,    16'h7FFF, 1'b0, UNTYPED},
			'{CMD_REMOVE, 16'h0000, 1'b0, UNTYPED},
			// The duplicate search must look past the slot freed just now.
			'{CMD_ADD,    16'hFFFF, 1'b0, UNTYPED},
			'{CMD_ADD,    16'h0001, 1'b0, UNTYPED},
			'{CMD_REMOVE, 16'h1234, 1'b1, '{ST_NOT_FOUND, 6'd0, 7'd4}},
			'{CMD_REMOVE, 16'hFFFF, 1'b0, UNTYPED},
			'{CMD_REMOVE, 16'hFFFF, 1'b1, '{ST_NOT_FOUND, 6'd0, 7'd3}},
			'{CMD_REMOVE, 16'h8000, 1'b0, UNTYPED},
			'{CMD_ADD,    16'h5555, 1'b0, UNTYPED},
			'{CMD_ADD,    16'hAAAA, 1'b0, UNTYPED},
			'{CMD_ADD,    16'h00FF, 1'b0, UNTYPED},
			'{CMD_REMOVE, 16'h7FFF, 1'b0, UNTYPED},
			'{CMD_REMOVE, 16'h0001, 1'b0, UNTYPED},
			'{CMD_REMOVE, 16'h5555, 1'b0, UNTYPED},
			'{CMD_REMOVE, 16'hAAAA, 1'b0, UNTYPED},
			'{CMD_REMOVE, 16'h00FF, 1'b0, UNTYPED},
			'{CMD_ADD,    16'hFF00, 1'b0, UNTYPED},
			'{CMD_REMOVE, 16'hFF00, 1'b0, UNTYPED}
		};
		for (int i = 0; i < TBL_SLOTS; i++) begin
			m_busy[i] = 1'b0;
			m_handle[i] = '0;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (intro_rows[i]) begin
			next_turn();
			offer(intro_rows[i].op, intro_rows[i].hdl, intro_rows[i].typed,
				intro_rows[i].want);
		end

		// Fill the table past full, then churn it while it stays near full.
		run_phase(90, 100, 5, ANY_HANDLE, -1);
		run_phase(300, 55, 60, ANY_HANDLE, 100);
		wait_all_answered();

		idle_on = 1'b0;
		run_phase(250, 50, 50, ANY_HANDLE, -1);
		wait_all_answered();
		idle_on = 1'b1;

		// Drain to empty, then work a small handle space and refill.
		run_phase(200, 10, 80, ANY_HANDLE, -1);
		run_phase(400, 55, 30, 16'd31, -1);
		run_phase(360, 65, 40, ANY_HANDLE, -1);
		wait_all_answered();

		repeat (TBL_SLOTS + 8) @(posedge clk);
		if (answer_q.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, answer_q.size());
			mismatch_cnt++;
		end
		if (mismatch_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[connection_slot_table_unit.f]
design/csl_pkg.sv
design/csl_mem.sv
design/csl_ctrl.sv
design/connection_slot_table_unit.sv
design/csl_checker.sv
bench/tb_connection_slot_table_unit.sv
